// ----- rtl/core/abm_pkg.sv -----
package abm_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VERTEX_W     = 6;
  localparam int COUNT_W      = 7;
  localparam int EDGES_W      = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 7;
  localparam int IN_DATA_W    = 16;
  localparam int IN_USER_W    = 2;
  localparam int OUT_DATA_W   = 24;

  localparam logic [COUNT_W-1:0] VCOUNT_RESET = COUNT_W'(MAX_VERTICES);
  localparam logic [COUNT_W-1:0] VCOUNT_MAX   = COUNT_W'(MAX_VERTICES);

  localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IS_DIRECTED  = 2'd1;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_FIRST = 2'd2,
    FUNC_NEXT  = 2'd3
  } func_t;

  typedef struct packed {
    logic accept;
    logic resolve;
    logic mirror;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_mirror;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/core/adjacency_bit_matrix.sv -----
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid/s_tready    s_tuser func; s_tdata from_vertex, to_vertex
// m_*      out  m_tvalid/m_tready    m_tdata hit, neighbour, edges_total, range_error
// cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each item runs from accept through a lookup step to the result load; a new item
// is taken only after that load. A new undirected edge between two different vertices
// adds a mirror step, as the row memory has one write port and needs a second write.
// A stalled result holds the following item at its own load, and no further accept.
// Reset clears the per-row valid flags at once; rows read as empty until written.
// Configuration writes are taken every cycle.
module adjacency_bit_matrix (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [abm_pkg::IN_DATA_W-1:0]   s_tdata,   // [5:0] from_vertex, [11:6] to_vertex
  input  logic [abm_pkg::IN_USER_W-1:0]   s_tuser,   // [1:0] func
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [abm_pkg::OUT_DATA_W-1:0]  m_tdata,   // [0] hit, [6:1] neighbour,
                                                     // [19:7] edges_total, [20] range_error
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [abm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [abm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import abm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  abm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  abm_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- rtl/core/abm_ctrl.sv -----
module abm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  abm_pkg::stat_t stat,
  output abm_pkg::cmd_t  cmd
);
  import abm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_MIRROR,
    ST_FINISH
  } state_t;

  state_t state;
  logic   in_ready;

  assign s_tready    = in_ready;
  assign cmd.accept  = in_ready && s_tvalid;
  assign cmd.resolve = (state == ST_LOOKUP);
  assign cmd.mirror  = (state == ST_MIRROR);
  assign cmd.emit    = (state == ST_FINISH) && stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.accept) begin
            state    <= ST_LOOKUP;
            in_ready <= 1'b0;
          end
        end
        ST_LOOKUP: begin
          if (stat.need_mirror) begin
            state <= ST_MIRROR;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_MIRROR: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (stat.out_free) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/abm_dpath.sv -----
module abm_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [abm_pkg::IN_DATA_W-1:0]        s_tdata,
  input  logic [abm_pkg::IN_USER_W-1:0]        s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [abm_pkg::OUT_DATA_W-1:0]       m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [abm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [abm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  abm_pkg::cmd_t                        cmd,
  output abm_pkg::stat_t                       stat
);
  import abm_pkg::*;

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] rd_row;
  logic                    rd_ok;

  logic [COUNT_W-1:0]  vertex_count;
  logic                is_directed;
  logic [EDGES_W-1:0]  edges;

  func_t               op_q;
  logic [VERTEX_W-1:0] v_q;
  logic [VERTEX_W-1:0] w_q;
  logic                err_q;

  func_t               in_func;
  logic [VERTEX_W-1:0] in_from;
  logic [VERTEX_W-1:0] in_to;
  logic [COUNT_W-1:0]  n_active;
  logic                in_err;

  logic [MAX_VERTICES-1:0] row;
  logic                    bit_vw;
  logic                    add_new;
  logic [COUNT_W-1:0]      start;
  logic [MAX_VERTICES-1:0] avail;
  logic [MAX_VERTICES-1:0] cand;
  logic [MAX_VERTICES-1:0] lowest;
  logic [VERTEX_W-1:0]     found_idx;
  logic                    res_hit;
  logic [VERTEX_W-1:0]     res_nb;
  logic                    hit_q;
  logic [VERTEX_W-1:0]     nb_q;

  logic [VERTEX_W-1:0]     rd_addr;
  logic                    wr_en;
  logic [VERTEX_W-1:0]     wr_addr;
  logic [MAX_VERTICES-1:0] wr_data;

  assign in_func = func_t'(s_tuser);
  assign in_from = s_tdata[VERTEX_W-1:0];
  assign in_to   = s_tdata[2*VERTEX_W-1:VERTEX_W];

  assign n_active = (vertex_count > VCOUNT_MAX) ? VCOUNT_MAX : vertex_count;
  assign in_err   = ({1'b0, in_from} >= n_active) ||
                    (((in_func == FUNC_ADD) || (in_func == FUNC_QUERY)) &&
                     ({1'b0, in_to} >= n_active));

  assign row     = rd_ok ? rd_row : '0;
  assign bit_vw  = row[w_q];
  assign add_new = (op_q == FUNC_ADD) && !err_q && !bit_vw;

  assign start = (op_q == FUNC_FIRST) ? '0 : COUNT_W'({1'b0, w_q} + 7'd1);

  always_comb begin
    for (int c = 0; c < MAX_VERTICES; c++) begin
      avail[c] = (COUNT_W'(c) < n_active) && (COUNT_W'(c) >= start);
    end
  end

  assign cand   = row & avail;
  assign lowest = cand & (~cand + MAX_VERTICES'(1));

  always_comb begin
    found_idx = '0;
    for (int c = 0; c < MAX_VERTICES; c++) begin
      if (lowest[c]) begin
        found_idx = found_idx | VERTEX_W'(c);
      end
    end
  end

  always_comb begin
    unique case (op_q)
      FUNC_ADD, FUNC_QUERY: begin
        res_hit = !err_q && bit_vw;
        res_nb  = '0;
      end
      FUNC_FIRST, FUNC_NEXT: begin
        res_hit = !err_q && (|cand);
        res_nb  = (!err_q && (|cand)) ? found_idx : '0;
      end
      default: begin
        res_hit = 1'b0;
        res_nb  = '0;
      end
    endcase
  end

  assign stat.need_mirror = cmd.resolve && add_new && !is_directed && (v_q != w_q);
  assign stat.out_free    = !m_tvalid || m_tready;

  assign rd_addr = cmd.accept ? in_from : w_q;
  assign wr_en   = (cmd.resolve && add_new) || cmd.mirror;
  assign wr_addr = cmd.mirror ? w_q : v_q;
  assign wr_data = row | (MAX_VERTICES'(1) << (cmd.mirror ? v_q : w_q));

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    rd_row <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      rd_ok <= row_valid[rd_addr];
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
      is_directed  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_VERTEX_COUNT) begin
        vertex_count <= cfg_data;
      end else if (cfg_index == CFG_IS_DIRECTED) begin
        is_directed <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edges <= '0;
    end else if (cmd.resolve && add_new) begin
      edges <= edges + EDGES_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= in_func;
      v_q   <= in_from;
      w_q   <= in_to;
      err_q <= in_err;
    end
    if (cmd.resolve) begin
      hit_q <= res_hit;
      nb_q  <= res_nb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {3'b000, err_q, edges, nb_q, hit_q};
    end
  end

`ifndef SYNTHESIS
  a_edges_step: assert property (@(posedge clk) disable iff (rst)
    (edges != $past(edges)) |-> (edges == EDGES_W'($past(edges) + 1'b1)))
    else $error("edge counter moved by more than one");

  a_mirror_undirected: assert property (@(posedge clk) disable iff (rst)
    cmd.mirror |-> (!is_directed && $past(cmd.resolve)))
    else $error("mirror write outside undirected add");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("result not presented after load");

  a_err_no_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[20]))
    else $error("hit reported with range error");
`endif

endmodule
